FILE: rtl/lrukv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrukv_pkg
// Types and constants shared by the lru key/value cache modules.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  typedef logic signed [31:0] key_t;
  typedef logic signed [31:0] value_t;

  localparam int CAP_W = 5;
  typedef logic [CAP_W-1:0] cap_t;

  localparam cap_t   CAP_RESET  = 5'd16;
  localparam logic   ACTION_GET = 1'b0;
  localparam logic   ACTION_PUT = 1'b1;
  localparam value_t MISS_VALUE = -32'sd1;
  localparam value_t PUT_VALUE  = 32'sd0;

  typedef struct packed {
    logic   action;
    key_t   key;
    value_t value_in;
  } item_t;

  typedef struct packed {
    logic   found;
    value_t read_value;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lrukv_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrukv_lookup
// Parallel key compare over the valid slots, first match and its value.
// ----------------------------------------------------------------------------
module lrukv_lookup #(
  parameter int ENTRIES = 16,
  localparam int OCC_W = $clog2(ENTRIES + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrukv_pkg::key_t    key,
  input  wire lrukv_pkg::key_t    slot_key [ENTRIES],
  input  wire lrukv_pkg::value_t  slot_value [ENTRIES],
  input  wire logic [OCC_W-1:0]   occupancy,
  output logic                    hit,
  output logic [ENTRIES-1:0]      first,
  output lrukv_pkg::value_t       hit_value
);
  import lrukv_pkg::*;

  logic [ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (OCC_W'(i) < occupancy) && (slot_key[i] == key);
    end
  end

  // lowest set bit, i.e. the most recent matching slot
  assign first = match & (~match + ENTRIES'(1));
  assign hit   = |match;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (first[i] ? slot_value[i] : value_t'(0));
    end
  end

`ifndef NO_ASSERTIONS
  a_first_onehot : assert property (@(posedge clk) disable iff (rst) $onehot0(first))
    else $error("more than one first match");
  a_first_hit : assert property (@(posedge clk) disable iff (rst) hit == (first != '0))
    else $error("hit and first match disagree");
  a_first_in_match : assert property (@(posedge clk) disable iff (rst) (first & ~match) == '0)
    else $error("first match outside match vector");
`endif

endmodule

`default_nettype wire

FILE: rtl/lrukv_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrukv_store
// Slot registers kept in recency order, with one-step shift and fill count.
// ----------------------------------------------------------------------------
module lrukv_store #(
  parameter int ENTRIES = 16,
  localparam int OCC_W = $clog2(ENTRIES + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               update,
  input  wire lrukv_pkg::item_t   item,
  input  wire logic               hit,
  input  wire logic [ENTRIES-1:0] first,
  input  wire lrukv_pkg::value_t  hit_value,
  input  wire logic [OCC_W-1:0]   eff_cap,
  output lrukv_pkg::key_t         slot_key [ENTRIES],
  output lrukv_pkg::value_t       slot_value [ENTRIES],
  output logic [OCC_W-1:0]        occupancy
);
  import lrukv_pkg::*;

  logic               is_put;
  logic               write;
  logic [ENTRIES-1:0] shift_mask;
  value_t             front_value;
  logic [OCC_W-1:0]   occupancy_next;

  assign is_put = (item.action == ACTION_PUT);
  assign write  = update && (hit || is_put);

  // on a hit only slots up to the hit position move back
  assign shift_mask  = hit ? (first | (first - ENTRIES'(1))) : '1;
  assign front_value = (is_put || !hit) ? item.value_in : hit_value;

  assign occupancy_next = (occupancy >= eff_cap) ? eff_cap : occupancy + OCC_W'(1);

  always_ff @(posedge clk) begin
    if (write) begin
      slot_key[0]   <= item.key;
      slot_value[0] <= front_value;
      for (int i = 1; i < ENTRIES; i++) begin
        if (shift_mask[i]) begin
          slot_key[i]   <= slot_key[i-1];
          slot_value[i] <= slot_value[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (update && is_put && !hit) begin
      occupancy <= occupancy_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
      occupancy <= OCC_W'(ENTRIES))
    else $error("occupancy beyond entries");
  a_get_keeps_occ : assert property (@(posedge clk) disable iff (rst)
      update && item.action == ACTION_GET |=> $stable(occupancy))
    else $error("get changed occupancy");
  a_insert_fills : assert property (@(posedge clk) disable iff (rst)
      update && is_put && !hit |=> occupancy != '0)
    else $error("insert left cache empty");
`endif

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel  ports                        handshake
//   request  start, busy, item            beat taken when start && !busy
//   result   done, result                 one-cycle strobe, no back-pressure
//   config   cfg_valid, cfg_ready, cfg_data  beat taken when valid && ready
//
// A request beat is registered, then looked up and applied in the next cycle;
// done is high in the cycle after that, one result per request.
// A new request can be taken every cycle: the compare across all slots and
// the one-step recency shift are both combinational on the staged item.
// busy and cfg_ready are only held off during reset; the cache comes out of
// reset empty with capacity 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire lrukv_pkg::item_t  item,
  output logic                   done,
  output lrukv_pkg::result_t     result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [lrukv_pkg::CAP_W-1:0] cfg_data
);
  import lrukv_pkg::*;

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  item_t            staged;
  logic             staged_valid;
  cap_t             capacity;
  logic [CW-1:0]    cap_ext;
  logic [CW-1:0]    cap_sat;
  logic [OCC_W-1:0] eff_cap;

  key_t             slot_key [ENTRIES];
  value_t           slot_value [ENTRIES];
  logic [OCC_W-1:0] occupancy;
  logic             hit;
  logic [ENTRIES-1:0] first;
  value_t           hit_value;
  result_t          result_next;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // zero counts as one, anything above the slot count saturates
  assign cap_ext = CW'(capacity);
  assign cap_sat = (capacity == '0) ? CW'(1) :
                   (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
  assign eff_cap = cap_sat[OCC_W-1:0];

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      staged <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      staged_valid <= 1'b0;
    end else begin
      staged_valid <= start && !busy;
    end
  end

  lrukv_lookup #(.ENTRIES(ENTRIES)) u_lookup (
    .clk        (clk),
    .rst        (rst),
    .key        (staged.key),
    .slot_key   (slot_key),
    .slot_value (slot_value),
    .occupancy  (occupancy),
    .hit        (hit),
    .first      (first),
    .hit_value  (hit_value)
  );

  lrukv_store #(.ENTRIES(ENTRIES)) u_store (
    .clk        (clk),
    .rst        (rst),
    .update     (staged_valid),
    .item       (staged),
    .hit        (hit),
    .first      (first),
    .hit_value  (hit_value),
    .eff_cap    (eff_cap),
    .slot_key   (slot_key),
    .slot_value (slot_value),
    .occupancy  (occupancy)
  );

  always_comb begin
    result_next.found = hit;
    if (staged.action == ACTION_PUT) begin
      result_next.read_value = PUT_VALUE;
    end else if (hit) begin
      result_next.read_value = hit_value;
    end else begin
      result_next.read_value = MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (staged_valid) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= staged_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_beat_gives_result : assert property (@(posedge clk) disable iff (rst)
      staged_valid |=> done)
    else $error("request beat without result");
  a_no_spurious_result : assert property (@(posedge clk) disable iff (rst)
      !staged_valid |=> !done)
    else $error("result without request beat");
  a_eff_cap_range : assert property (@(posedge clk) disable iff (rst)
      eff_cap != '0 && eff_cap <= OCC_W'(ENTRIES))
    else $error("effective capacity out of range");
`endif

endmodule

`default_nettype wire
